@@ src/life_generation_stencil_assert.svh @@
// Assertion helpers for the stencil RTL.
`ifndef LIFE_GENERATION_STENCIL_ASSERT_SVH
`define LIFE_GENERATION_STENCIL_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define LGS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil check failed");

// Next-cycle implication, checked out of reset only.
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil check failed");

`endif

@@ src/lgs_pkg.sv @@
package lgs_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = 11;
  localparam int POS_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] MAX_ROWS_C    = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] MAX_COLUMNS_C = CNT_W'(MAX_COLUMNS);

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COLUMNS = 2'd1;

  // window layout: column k in bits 3k+2:3k, bit 3k is the top row
  localparam logic [8:0] TOP_ROW_MASK  = 9'h049;
  localparam logic [8:0] LEFT_COL_MASK = 9'h007;
  localparam logic [8:0] CENTER_BIT    = 9'h010;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;  // bit 0 upper line, bit 1 middle line
  } lb_wr_t;

  function automatic logic next_state(input logic [8:0] w);
    logic [8:0] n;
    logic [3:0] cnt;
    n = w & ~CENTER_BIT;
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + 4'(n[i]);
    end
    return (cnt == 4'd3) || ((w & CENTER_BIT) != 9'd0 && cnt == 4'd2);
  endfunction

  function automatic logic [CNT_W-1:0] effective(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] mx);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/lgs_line_buf.sv @@
module lgs_line_buf (
  input  logic                      clk,
  input  lgs_pkg::lb_wr_t           wr,
  input  logic [lgs_pkg::COL_W-1:0] rd_addr,
  output logic [1:0]                rd_data
);

  logic [1:0] mem [lgs_pkg::MAX_COLUMNS];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // forward a same-cycle write so a one-column field sees its own data
  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == rd_addr) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/lgs_col_cell.sv @@
module lgs_col_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic [2:0] col_in,
  output logic [2:0] col_q
);

  logic [2:0] col_r;
  logic [2:0] col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_q = col_r;

endmodule

@@ src/life_generation_stencil.sv @@
// Game of Life (B3/S23) next-generation stencil. Cells of one generation enter in
// raster order, one item per clock; each result leaves one row plus one column
// behind its input, so after the last cell send field_columns + 1 flush items
// (in_mode = 1) to drain the frame. A flush with nothing in flight is dropped.
// Throughput is one item per cycle while no held result stalls the input, set by
// the single-port-write line buffer (one read and one write per cycle) feeding a
// three-column window that shifts once per item. A result shows on the outputs
// the cycle after the item that completes it; the output register hands it over
// in the same cycle a new item enters, so a result held by the receiver holds the
// input as well. Cells outside the field count as dead. Writing field_rows or
// field_columns restarts the frame. No clearing pass is needed after reset.
`include "life_generation_stencil_assert.svh"

module life_generation_stencil (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic                          in_cell_alive,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_next_alive,
  output logic [lgs_pkg::POS_W-1:0]     out_row,
  output logic [lgs_pkg::POS_W-1:0]     out_column,
  output logic                          out_frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CNT_W-1:0]     cfg_data
);

  logic [lgs_pkg::CNT_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [lgs_pkg::CNT_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic [lgs_pkg::CNT_W-1:0] rows_eff, cols_eff;
  logic [lgs_pkg::CNT_W-1:0] row_r, row_nxt;
  logic [lgs_pkg::COL_W-1:0] col_r, col_nxt;

  logic out_valid_r, out_valid_nxt;
  logic next_alive_r, next_alive_nxt;
  logic [lgs_pkg::POS_W-1:0] out_row_r, out_row_nxt;
  logic [lgs_pkg::POS_W-1:0] out_column_r, out_column_nxt;
  logic frame_last_r, frame_last_nxt;

  logic cfg_wr, restart;
  logic accept, skip, step, alive_in;
  logic emit_a, emit_b, emit, last;
  logic [1:0] lb_rd;
  lgs_pkg::lb_wr_t lb_wr;
  logic [lgs_pkg::COL_W-1:0] lb_rd_addr;
  logic [2:0] col_new;
  logic [2:0] col_q [3];
  logic [2:0] col_in [3];
  logic [8:0] win_now, win_new, wa, wb, w_sel;
  logic [lgs_pkg::CNT_W-1:0] orow, col_plus, ocol_plus;
  logic [lgs_pkg::COL_W-1:0] ocol;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  assign rows_eff = lgs_pkg::effective(rows_cfg_r, lgs_pkg::MAX_ROWS_C);
  assign cols_eff = lgs_pkg::effective(cols_cfg_r, lgs_pkg::MAX_COLUMNS_C);

  assign skip     = in_mode && row_r == '0 && col_r == '0;
  assign step     = accept && !skip;
  assign alive_in = !in_mode && in_cell_alive && (row_r < rows_eff);

  // line buffer: bit 0 is two rows up, bit 1 one row up
  assign col_new = {alive_in, lb_rd[1], lb_rd[0]};
  assign lb_wr.en   = step;
  assign lb_wr.addr = col_r;
  assign lb_wr.data = {alive_in, lb_rd[1]};

  lgs_line_buf u_line_buf (
    .clk     (clk),
    .wr      (lb_wr),
    .rd_addr (lb_rd_addr),
    .rd_data (lb_rd)
  );

  // window chain: cell 2 is the newest column, cell 0 the oldest
  assign col_in[2] = col_new;
  assign col_in[1] = col_q[2];
  assign col_in[0] = col_q[1];

  for (genvar k = 0; k < 3; k++) begin : g_cell
    lgs_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .col_in   (col_in[k]),
      .col_q    (col_q[k])
    );
  end

  assign win_now = {col_q[2], col_q[1], col_q[0]};
  assign win_new = {col_new, win_now[8:3]};

  // end-of-row result for the row two above uses the old window, right column dead
  assign emit_a = (col_r == '0) && (row_r >= lgs_pkg::CNT_W'(2));
  assign emit_b = (col_r != '0) && (row_r >= lgs_pkg::CNT_W'(1));
  assign emit   = step && (emit_a || emit_b);

  always_comb begin
    wa = {3'b000, win_now[8:3]};
    if (cols_eff == lgs_pkg::CNT_W'(1)) begin
      wa = wa & ~lgs_pkg::LEFT_COL_MASK;
    end
    if (row_r == lgs_pkg::CNT_W'(2)) begin
      wa = wa & ~lgs_pkg::TOP_ROW_MASK;
    end
    wb = win_new;
    if (col_r == lgs_pkg::COL_W'(1)) begin
      wb = wb & ~lgs_pkg::LEFT_COL_MASK;
    end
    if (row_r == lgs_pkg::CNT_W'(1)) begin
      wb = wb & ~lgs_pkg::TOP_ROW_MASK;
    end
    if (emit_a) begin
      w_sel = wa;
      orow  = row_r - lgs_pkg::CNT_W'(2);
      ocol  = lgs_pkg::COL_W'(cols_eff - lgs_pkg::CNT_W'(1));
    end else begin
      w_sel = wb;
      orow  = row_r - lgs_pkg::CNT_W'(1);
      ocol  = col_r - lgs_pkg::COL_W'(1);
    end
  end

  assign ocol_plus = {1'b0, ocol} + lgs_pkg::CNT_W'(1);
  assign last      = (orow + lgs_pkg::CNT_W'(1) == rows_eff) && (ocol_plus == cols_eff);
  assign col_plus  = {1'b0, col_r} + lgs_pkg::CNT_W'(1);
  assign restart   = emit && last;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (cfg_wr && cfg_index == lgs_pkg::CFG_FIELD_ROWS) begin
      rows_cfg_nxt = cfg_data;
    end
    if (cfg_wr && cfg_index == lgs_pkg::CFG_FIELD_COLUMNS) begin
      cols_cfg_nxt = cfg_data;
    end
    priority if (cfg_wr && (cfg_index == lgs_pkg::CFG_FIELD_ROWS ||
                            cfg_index == lgs_pkg::CFG_FIELD_COLUMNS)) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (step) begin
      if (col_plus >= cols_eff) begin
        col_nxt = '0;
        row_nxt = row_r + lgs_pkg::CNT_W'(1);
      end else begin
        col_nxt = col_plus[lgs_pkg::COL_W-1:0];
      end
    end
  end

  // read one item ahead so data for the next column is ready at accept
  assign lb_rd_addr = rst_n ? col_nxt : '0;

  always_comb begin
    next_alive_nxt = next_alive_r;
    out_row_nxt    = out_row_r;
    out_column_nxt = out_column_r;
    frame_last_nxt = frame_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      next_alive_nxt = lgs_pkg::next_state(w_sel);
      out_row_nxt    = orow[lgs_pkg::POS_W-1:0];
      out_column_nxt = ocol[lgs_pkg::POS_W-1:0];
      frame_last_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= lgs_pkg::MAX_ROWS_C;
      cols_cfg_r  <= lgs_pkg::MAX_COLUMNS_C;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_alive_r <= next_alive_nxt;
    out_row_r    <= out_row_nxt;
    out_column_r <= out_column_nxt;
    frame_last_r <= frame_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_next_alive = next_alive_r;
  assign out_row        = out_row_r;
  assign out_column     = out_column_r;
  assign out_frame_last = frame_last_r;

  `LGS_ASSERT_IMPL(a_col_in_range, clk, rst_n, 1'b1, {1'b0, col_r} < cols_eff)
  `LGS_ASSERT_IMPL(a_last_is_corner, clk, rst_n, out_valid_r && frame_last_r,
                   {1'b0, out_column_r} + lgs_pkg::CNT_W'(1) == cols_eff)
  `LGS_ASSERT_NEXT(a_restart_clears, clk, rst_n, restart && !cfg_wr,
                   row_r == '0 && col_r == '0 && out_valid_r && frame_last_r)

endmodule

@@ tb/life_generation_stencil_checker.sv @@
`timescale 1ns / 100ps

module generation_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_mode,
  input  logic                          in_cell_alive,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_next_alive,
  input  logic [lgs_pkg::POS_W-1:0]     out_row,
  input  logic [lgs_pkg::POS_W-1:0]     out_column,
  input  logic                          out_frame_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CNT_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            cells_owed
);

  localparam int CW = lgs_pkg::CNT_W;
  localparam int PW = lgs_pkg::POS_W;

  // window: column k in bits 3k+2:3k, top row in bit 3k
  localparam logic [8:0] TOP_EDGE  = 9'h049;
  localparam logic [8:0] LEFT_EDGE = 9'h007;
  localparam logic [8:0] SELF_CELL = 9'h010;

  typedef struct packed {
    logic          alive;
    logic [PW-1:0] row;
    logic [PW-1:0] column;
    logic          last;
  } gen_cell_t;

  gen_cell_t next_gen_cells[$];
  gen_cell_t oldest;

  logic [CW-1:0] rows_setting;
  logic [CW-1:0] cols_setting;
  logic          upper_cells [lgs_pkg::MAX_COLUMNS];
  logic          middle_cells[lgs_pkg::MAX_COLUMNS];
  logic [8:0]    window;
  logic [CW-1:0] row_pos;
  logic [CW-1:0] col_pos;

  initial mismatches = 0;
  initial cells_owed = 0;

  function automatic logic [CW-1:0] active_size(input logic [CW-1:0] setting,
                                                input int ceiling);
    if (setting == '0) return CW'(1);
    if (int'(setting) > ceiling) return CW'(ceiling);
    return setting;
  endfunction

  function automatic logic b3s23(input logic [8:0] w);
    int n;
    n = $countones(w & ~SELF_CELL);
    return (n == 3) || (n == 2 && w[4]);
  endfunction

  task automatic predict_item(input logic flush, input logic alive);
    logic [CW-1:0] rows;
    logic [CW-1:0] cols;
    logic [CW-1:0] r;
    logic [CW-1:0] c;
    logic [CW-1:0] orow;
    logic [CW-1:0] ocol;
    logic          fed_alive;
    logic          emit;
    logic [8:0]    w;
    logic [8:0]    fresh;
    gen_cell_t     e;
    rows = active_size(rows_setting, lgs_pkg::MAX_ROWS);
    cols = active_size(cols_setting, lgs_pkg::MAX_COLUMNS);
    r = row_pos;
    c = col_pos;
    emit = 1'b0;
    w = '0;
    orow = '0;
    ocol = '0;
    // a flush with nothing in flight is dropped
    if (flush && r == '0 && c == '0) return;
    fed_alive = flush ? 1'b0 : alive;
    if (r >= rows) fed_alive = 1'b0;
    // start of a row finishes the last cell two rows up
    if (c == '0 && r >= 2) begin
      w = window >> 3;
      if (cols == 1) w &= ~LEFT_EDGE;
      if (r == 2) w &= ~TOP_EDGE;
      emit = 1'b1;
      orow = r - CW'(2);
      ocol = cols - CW'(1);
    end
    fresh = {6'b0, fed_alive, middle_cells[c[PW-1:0]], upper_cells[c[PW-1:0]]};
    upper_cells[c[PW-1:0]] = middle_cells[c[PW-1:0]];
    middle_cells[c[PW-1:0]] = fed_alive;
    window = (window >> 3) | (fresh << 6);
    if (c >= 1 && r >= 1) begin
      w = window;
      if (c == 1) w &= ~LEFT_EDGE;
      if (r == 1) w &= ~TOP_EDGE;
      emit = 1'b1;
      orow = r - CW'(1);
      ocol = c - CW'(1);
    end
    if (int'(c) + 1 >= int'(cols)) begin
      col_pos = '0;
      row_pos = r + CW'(1);
    end else begin
      col_pos = c + CW'(1);
    end
    if (!emit) return;
    e.alive = b3s23(w);
    e.row = orow[PW-1:0];
    e.column = ocol[PW-1:0];
    e.last = (int'(orow) + 1 == int'(rows)) && (int'(ocol) + 1 == int'(cols));
    next_gen_cells.push_back(e);
    if (e.last) begin
      row_pos = '0;
      col_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_setting = CW'(lgs_pkg::MAX_ROWS);
      cols_setting = CW'(lgs_pkg::MAX_COLUMNS);
      for (int i = 0; i < lgs_pkg::MAX_COLUMNS; i++) begin
        upper_cells[i] = 1'b0;
        middle_cells[i] = 1'b0;
      end
      window = '0;
      row_pos = '0;
      col_pos = '0;
      next_gen_cells.delete();
      cells_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lgs_pkg::CFG_FIELD_ROWS: begin
            rows_setting = cfg_data;
            row_pos = '0;
            col_pos = '0;
          end
          lgs_pkg::CFG_FIELD_COLUMNS: begin
            cols_setting = cfg_data;
            row_pos = '0;
            col_pos = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_item(in_mode, in_cell_alive);
      if (out_valid && out_ready) begin
        if (next_gen_cells.size() == 0) begin
          $error("unexpected result at row %0d column %0d", out_row, out_column);
          mismatches++;
        end else begin
          oldest = next_gen_cells.pop_front();
          if (out_next_alive !== oldest.alive) begin
            $error("next_alive expected %0d actual %0d", oldest.alive, out_next_alive);
            mismatches++;
          end
          if (out_row !== oldest.row) begin
            $error("out_row expected %0d actual %0d", oldest.row, out_row);
            mismatches++;
          end
          if (out_column !== oldest.column) begin
            $error("out_column expected %0d actual %0d", oldest.column, out_column);
            mismatches++;
          end
          if (out_frame_last !== oldest.last) begin
            $error("frame_last expected %0d actual %0d", oldest.last, out_frame_last);
            mismatches++;
          end
        end
      end
      cells_owed <= next_gen_cells.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 530;
  localparam int SETTLE       = 16;
  localparam int CHOP_LONG    = 48;

  // indexes past the register list, writes there are ignored
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_COMB, RX_SCARCE} rx_pattern_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_mode = 1'b0;
  logic                          in_cell_alive = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_next_alive;
  logic [lgs_pkg::POS_W-1:0]     out_row;
  logic [lgs_pkg::POS_W-1:0]     out_column;
  logic                          out_frame_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lgs_pkg::CNT_W-1:0]     cfg_data = '0;

  int          mismatches;
  int          cells_owed;
  int          cycles = 0;
  int          burst_left = 0;
  int          rx_left = 0;
  int          rx_phase = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int          random_items = 0;

  always #4 clk = ~clk;

  life_generation_stencil dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_cell_alive (in_cell_alive),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_alive(out_next_alive),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  generation_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_cell_alive (in_cell_alive),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_alive(out_next_alive),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .cells_owed    (cells_owed)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("life_generation_stencil regression: fail");
      $finish;
    end
  end

  // receiver back-pressure, one of four patterns picked at random
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
      RX_COMB:   out_ready <= ((rx_phase % 5) < 2);
      default:   out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  task automatic send_item(input logic mode, input logic alive);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cell_alive <= alive;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every owed result is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lgs_pkg::CNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a field of random cells; chop > 0 stops after that many cells (frame aborted later)
  task automatic run_frame(input int rows_n, input int cols_n, input int pct,
                           input int chop, output int sent);
    int total;
    total = (chop != 0) ? chop : rows_n * cols_n;
    for (int i = 0; i < total; i++) send_item(1'b0, $urandom_range(0, 99) < pct);
    sent = total;
    if (chop == 0) begin
      // trailing items: flushes, or cell items that fall past the last row
      for (int j = 0; j <= cols_n; j++) begin
        send_item($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    int rows_n;
    int cols_n;
    int pct;
    int chop;
    int sent;
    bit need_cfg;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // flush with nothing in flight
    send_item(1'b1, 1'b1);
    write_reg(CFG_SPARE_LO, 11'h7FF);
    write_reg(CFG_SPARE_HI, 11'h000);

    // zero sizes act as a 1x1 field: a lone live cell dies
    write_reg(lgs_pkg::CFG_FIELD_ROWS, 11'd0);
    write_reg(lgs_pkg::CFG_FIELD_COLUMNS, 11'd0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);

    // 3x3 blinker, horizontal bar turns vertical
    write_reg(lgs_pkg::CFG_FIELD_ROWS, 11'd3);
    write_reg(lgs_pkg::CFG_FIELD_COLUMNS, 11'd3);
    for (int i = 0; i < 9; i++) send_item(1'b0, (i / 3) == 1);
    repeat (4) send_item(1'b1, 1'b0);

    // 2x2 block; live cell items past the last row must count as dead
    write_reg(lgs_pkg::CFG_FIELD_ROWS, 11'd2);
    write_reg(lgs_pkg::CFG_FIELD_COLUMNS, 11'd2);
    repeat (4) send_item(1'b0, 1'b1);
    repeat (3) send_item(1'b0, 1'b1);

    // largest sizes, each along one axis only, frames cut short
    write_reg(lgs_pkg::CFG_FIELD_ROWS, 11'h7FF);
    write_reg(lgs_pkg::CFG_FIELD_COLUMNS, 11'd1);
    run_frame(lgs_pkg::MAX_ROWS, 1, $urandom_range(20, 60), CHOP_LONG, sent);
    write_reg(lgs_pkg::CFG_FIELD_ROWS, 11'd1);
    write_reg(lgs_pkg::CFG_FIELD_COLUMNS, 11'd1024);
    run_frame(1, lgs_pkg::MAX_COLUMNS, $urandom_range(20, 60), CHOP_LONG, sent);

    need_cfg = 1'b1;
    rows_n = 1;
    cols_n = 1;
    while (random_items < RANDOM_ITEMS) begin
      if (need_cfg || $urandom_range(0, 3) != 0) begin
        rows_n = $urandom_range(1, 10);
        cols_n = $urandom_range(1, 12);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(lgs_pkg::CFG_FIELD_ROWS,
                    (rows_n == 1 && $urandom_range(0, 1)) ? 11'd0 : lgs_pkg::CNT_W'(rows_n));
          write_reg(lgs_pkg::CFG_FIELD_COLUMNS, lgs_pkg::CNT_W'(cols_n));
        end else begin
          write_reg(lgs_pkg::CFG_FIELD_COLUMNS,
                    (cols_n == 1 && $urandom_range(0, 1)) ? 11'd0 : lgs_pkg::CNT_W'(cols_n));
          write_reg(lgs_pkg::CFG_FIELD_ROWS, lgs_pkg::CNT_W'(rows_n));
        end
      end
      case ($urandom_range(0, 3))
        0:       pct = 10;
        1:       pct = 35;
        2:       pct = 50;
        default: pct = 80;
      endcase
      chop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rows_n * cols_n) : 0;
      run_frame(rows_n, cols_n, pct, chop, sent);
      random_items += sent;
      need_cfg = (chop != 0);
      if (chop == 0) begin
        // stray flushes between frames are dropped
        repeat ($urandom_range(0, 2)) send_item(1'b1, 1'($urandom_range(0, 1)));
      end
    end

    drain();
    if (mismatches == 0 && cells_owed == 0) begin
      $display("life_generation_stencil regression: pass");
    end else begin
      $display("life_generation_stencil regression: fail");
    end
    $finish;
  end

endmodule
